// ===== hw/rtl/yuyv_to_normalized_rgb_planar_core_defines.svh =====
// ----------------------------------------------------------------------------
// YUYV to normalised RGB core: assertion macros
// Concurrent checks for simulation; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef YUYV_TO_NORMALIZED_RGB_PLANAR_CORE_DEFINES_SVH
`define YUYV_TO_NORMALIZED_RGB_PLANAR_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication
`define YTNRP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ytnrp: same-cycle check failed");

// Next-cycle implication
`define YTNRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ytnrp: next-cycle check failed");

`else

`define YTNRP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define YTNRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/ytnrp_pkg.sv =====
// ----------------------------------------------------------------------------
// YUYV to normalised RGB core: shared package
// Types, command and status structs, coefficients and register indexes.
// ----------------------------------------------------------------------------
package ytnrp_pkg;

    localparam int DATA_W    = 24;
    localparam int CFG_DIM_W = 13;
    localparam int REG_IDX_W = 3;

    // Datapath widths (sized for FRAC_BITS up to 24)
    localparam int COEF_W = 26;
    localparam int PROD_W = COEF_W + 8;
    localparam int ACC_W  = 35;
    localparam int DIFF_W = 26;
    localparam int HALF_W = 12;
    localparam int PP_W   = DIFF_W + HALF_W + 1;
    localparam int P_W    = DIFF_W + DATA_W + 1;

    // BT.601 full-range coefficients, Q.24, signs folded in
    localparam logic signed [COEF_W-1:0] COEF_RV     =  26'sd23521657;
    localparam logic signed [COEF_W-1:0] COEF_GU_NEG = -26'sd5773644;
    localparam logic signed [COEF_W-1:0] COEF_GV_NEG = -26'sd11981214;
    localparam logic signed [COEF_W-1:0] COEF_BU     =  26'sd29729227;

    localparam logic [31:0] CLAMP_MAX = 32'hFF00_0000;

    localparam logic [DATA_W-1:0] SAT_POS = 24'h7F_FFFF;
    localparam logic [DATA_W-1:0] SAT_NEG = 24'h80_0000;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MEAN_RED      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MEAN_GREEN    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MEAN_BLUE     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INV_STD_RED   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_INV_STD_GREEN = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_INV_STD_BLUE  = 3'd7;

    typedef logic [2:0][DATA_W-1:0] t_ch24;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_MUL2,
        S_CLAMP,
        S_DIV,
        S_FIX,
        S_MLO,
        S_MHI,
        S_RND,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD,
        OP_MUL2,
        OP_CLAMP,
        OP_DIV,
        OP_FIX,
        OP_MLO,
        OP_MHI,
        OP_RND,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [1:0]        ch;
        logic              pix;
        logic [DATA_W-1:0] index;
        logic              last;
        logic              fend;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/ytnrp_if.sv =====
// ----------------------------------------------------------------------------
// YUYV to normalised RGB core: channel interfaces
// Macropixel input, pixel result and configuration write channels.
// ----------------------------------------------------------------------------
interface ytnrp_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;

    modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                    input ready);
    modport sink (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                  output ready);
endinterface

interface ytnrp_res_if import ytnrp_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [DATA_W-1:0]        pixel_index;
    logic signed [DATA_W-1:0] red_out;
    logic signed [DATA_W-1:0] green_out;
    logic signed [DATA_W-1:0] blue_out;
    logic                     last_of_item;
    logic                     frame_end;

    modport source (output valid, pixel_index, red_out, green_out, blue_out,
                    last_of_item, frame_end, input ready);
    modport sink (input valid, pixel_index, red_out, green_out, blue_out,
                  last_of_item, frame_end, output ready);
endinterface

interface ytnrp_cfg_if import ytnrp_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [REG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ytnrp_ctrl.sv =====
// ----------------------------------------------------------------------------
// YUYV to normalised RGB core: controller
// Sequences the shared datapath over pixels and channels; owns the frame counter.
// ----------------------------------------------------------------------------
`include "yuyv_to_normalized_rgb_planar_core_defines.svh"

module ytnrp_ctrl import ytnrp_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CFG_DIM_W-1:0] i_frame_width,
    input  logic [CFG_DIM_W-1:0] i_frame_height,
    output t_cmd                 o_cmd,
    input  t_sts                 i_sts
);

    localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int N_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int EXT_W = N_W + 1;
    localparam int DIM_W = CFG_DIM_W + 1;

    t_state             r_state, n_state;
    logic [1:0]         r_ch;
    logic               r_pix;
    logic               r_two;
    logic               r_fend0, r_fend1;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_cnt;

    logic [DIM_W-1:0]   w_w, w_h;
    logic [2*DIM_W-1:0] w_area;
    logic [EXT_W-1:0]   w_n, w_cnt, w_base, w_idx1, w_idx2;
    logic [CNT_W-1:0]   w_cnt_next;
    logic               w_capture;
    logic [CNT_W-1:0]   w_idx_sel;
    logic [CNT_W+23:0]  w_idx_ext;

    // Frame size, clipped to the supported range
    always_comb begin
        if (i_frame_width == '0) begin
            w_w = DIM_W'(1);
        end else if (DIM_W'(i_frame_width) > DIM_W'(MAX_WIDTH)) begin
            w_w = DIM_W'(MAX_WIDTH);
        end else begin
            w_w = DIM_W'(i_frame_width);
        end
        if (i_frame_height == '0) begin
            w_h = DIM_W'(1);
        end else if (DIM_W'(i_frame_height) > DIM_W'(MAX_HEIGHT)) begin
            w_h = DIM_W'(MAX_HEIGHT);
        end else begin
            w_h = DIM_W'(i_frame_height);
        end
    end

    assign w_area = w_w * w_h;
    assign w_n    = EXT_W'(w_area);
    assign w_cnt  = EXT_W'(r_cnt);
    // restart if a new frame size left the counter outside the frame
    assign w_base = (w_cnt >= w_n) ? '0 : w_cnt;
    assign w_idx1 = w_base + EXT_W'(1);
    assign w_idx2 = w_base + EXT_W'(2);
    assign w_cnt_next = (w_idx2 >= w_n) ? '0 : CNT_W'(w_idx2);

    assign w_capture = i_in_valid && o_in_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_LOAD;
            S_LOAD:  n_state = (r_ch == CH_GREEN) ? S_MUL2 : S_CLAMP;
            S_MUL2:  n_state = S_CLAMP;
            S_CLAMP: n_state = S_DIV;
            S_DIV:   if (i_sts.div_done) n_state = S_FIX;
            S_FIX:   n_state = S_MLO;
            S_MLO:   n_state = S_MHI;
            S_MHI:   n_state = S_RND;
            S_RND:   n_state = (r_ch == CH_BLUE) ? S_EMIT : S_LOAD;
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = (!r_pix && r_two) ? S_LOAD : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_idx_sel = r_pix ? (r_idx + CNT_W'(1)) : r_idx;
    assign w_idx_ext = {{24{1'b0}}, w_idx_sel};

    // Outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd.op    = OP_NONE;
        o_cmd.ch    = r_ch;
        o_cmd.pix   = r_pix;
        o_cmd.index = w_idx_ext[DATA_W-1:0];
        o_cmd.last  = r_pix || !r_two;
        o_cmd.fend  = r_pix ? r_fend1 : r_fend0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_CAPTURE;
            end
            S_LOAD:  o_cmd.op = OP_LOAD;
            S_MUL2:  o_cmd.op = OP_MUL2;
            S_CLAMP: o_cmd.op = OP_CLAMP;
            S_DIV:   o_cmd.op = OP_DIV;
            S_FIX:   o_cmd.op = OP_FIX;
            S_MLO:   o_cmd.op = OP_MLO;
            S_MHI:   o_cmd.op = OP_MHI;
            S_RND:   o_cmd.op = OP_RND;
            S_EMIT:  if (i_sts.out_free) o_cmd.op = OP_EMIT;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= CH_RED;
            r_pix   <= 1'b0;
            r_two   <= 1'b0;
            r_fend0 <= 1'b0;
            r_fend1 <= 1'b0;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_capture) begin
                r_ch    <= CH_RED;
                r_pix   <= 1'b0;
                r_two   <= (w_idx1 < w_n);
                r_fend0 <= (w_idx1 == w_n);
                r_fend1 <= (w_idx2 == w_n);
                r_idx   <= CNT_W'(w_base);
                r_cnt   <= w_cnt_next;
            end else if (r_state == S_RND && r_ch != CH_BLUE) begin
                r_ch <= r_ch + 2'd1;
            end else if (r_state == S_EMIT && i_sts.out_free && !r_pix && r_two) begin
                r_ch  <= CH_RED;
                r_pix <= 1'b1;
            end
        end
    end

    `YTNRP_ASSERT_NEXT(a_capture_starts, i_clk, i_rst_n, w_capture, r_state == S_LOAD)
    `YTNRP_ASSERT_IMPL(a_emit_has_room, i_clk, i_rst_n, o_cmd.op == OP_EMIT, i_sts.out_free)
    `YTNRP_ASSERT_IMPL(a_second_needs_pair, i_clk, i_rst_n, r_pix, r_two)
    `YTNRP_ASSERT_NEXT(a_div_waits, i_clk, i_rst_n, r_state == S_DIV && !i_sts.div_done, r_state == S_DIV)

endmodule

// ===== hw/rtl/ytnrp_dp.sv =====
// ----------------------------------------------------------------------------
// YUYV to normalised RGB core: datapath
// Shared colour, divide-by-255 and normalise unit with the output register.
// ----------------------------------------------------------------------------
`include "yuyv_to_normalized_rgb_planar_core_defines.svh"

module ytnrp_dp import ytnrp_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [7:0]         i_luma_first,
    input  logic [7:0]         i_chroma_blue,
    input  logic [7:0]         i_luma_second,
    input  logic [7:0]         i_chroma_red,
    input  t_ch24              i_mean,
    input  t_ch24              i_inv_std,
    ytnrp_res_if.source        o_res
);

    localparam int SHIFT = 24 - FRAC_BITS;
    localparam int X_W   = FRAC_BITS + 8;
    localparam int Q_W   = FRAC_BITS + 1;
    localparam logic [32:0] HALF_D = 33'((255 * (2 ** SHIFT)) / 2);
    localparam logic signed [P_W-1:0] ROUND_ADD = P_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [P_W-1:0] P_HI = P_W'(8388607);
    localparam logic signed [P_W-1:0] P_LO = P_W'(-8388608);

    logic [7:0]               r_y0, r_u, r_y1, r_v;
    logic signed [ACC_W-1:0]  r_acc;
    logic [X_W-1:0]           r_x;
    logic [Q_W-1:0]           r_q;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [P_W-1:0]    r_p;
    logic [DATA_W-1:0]        r_red, r_green, r_blue;
    logic                     r_o_valid;
    logic [DATA_W-1:0]        r_o_index;
    logic [DATA_W-1:0]        r_o_red, r_o_green, r_o_blue;
    logic                     r_o_last, r_o_fend;

    logic [7:0]               w_luma;
    logic signed [7:0]        w_cu, w_cv, w_chroma;
    logic signed [COEF_W-1:0] w_coef;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_load;
    logic [31:0]              w_clamp;
    logic [32:0]              w_cplus;
    logic [X_W-1:0]           w_t;
    logic [Q_W-1:0]           w_qf;
    logic [DATA_W-1:0]        w_mean, w_inv;
    logic [HALF_W-1:0]        w_half;
    logic signed [PP_W-1:0]   w_pp;
    logic signed [P_W-1:0]    w_rnd;
    logic [DATA_W-1:0]        w_sat;

    assign w_luma = i_cmd.pix ? r_y1 : r_y0;
    // flip the top bit: byte minus 128 as a signed byte
    assign w_cu = $signed(r_u ^ 8'h80);
    assign w_cv = $signed(r_v ^ 8'h80);

    always_comb begin
        w_coef   = '0;
        w_chroma = '0;
        w_mean   = '0;
        w_inv    = '0;
        case (i_cmd.ch)
            CH_RED: begin
                w_coef   = COEF_RV;
                w_chroma = w_cv;
                w_mean   = i_mean[0];
                w_inv    = i_inv_std[0];
            end
            CH_GREEN: begin
                w_coef   = COEF_GU_NEG;
                w_chroma = w_cu;
                w_mean   = i_mean[1];
                w_inv    = i_inv_std[1];
            end
            CH_BLUE: begin
                w_coef   = COEF_BU;
                w_chroma = w_cu;
                w_mean   = i_mean[2];
                w_inv    = i_inv_std[2];
            end
            default: begin
                w_coef   = '0;
                w_chroma = '0;
            end
        endcase
        // second green term
        if (i_cmd.op == OP_MUL2) begin
            w_coef   = COEF_GV_NEG;
            w_chroma = w_cv;
        end
    end

    assign w_prod = w_coef * w_chroma;
    assign w_load = $signed(ACC_W'({w_luma, 24'b0})) + ACC_W'(w_prod);

    // clamp to 0..255 in Q.24, then round and rescale to the Q.F grid over 2^SHIFT
    assign w_clamp = r_acc[ACC_W-1] ? '0 :
                     (r_acc > $signed(ACC_W'(CLAMP_MAX))) ? CLAMP_MAX : r_acc[31:0];
    assign w_cplus = {1'b0, w_clamp} + HALF_D;

    // divide by 255: 256*t + b = 255*t + (t + b)
    assign w_t = r_x >> 8;
    assign o_sts.div_done = (w_t == '0);

    assign w_qf = r_q + Q_W'(r_x == X_W'(255));

    assign w_half = (i_cmd.op == OP_MHI) ? w_inv[DATA_W-1:HALF_W] : w_inv[HALF_W-1:0];
    assign w_pp   = r_diff * $signed({1'b0, w_half});

    assign w_rnd = (r_p + ROUND_ADD) >>> FRAC_BITS;
    assign w_sat = (w_rnd > P_HI) ? SAT_POS :
                   (w_rnd < P_LO) ? SAT_NEG : w_rnd[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_y0 <= i_luma_first;
                r_u  <= i_chroma_blue;
                r_y1 <= i_luma_second;
                r_v  <= i_chroma_red;
            end
            OP_LOAD:  r_acc <= w_load;
            OP_MUL2:  r_acc <= r_acc + ACC_W'(w_prod);
            OP_CLAMP: begin
                r_x <= X_W'(w_cplus >> SHIFT);
                r_q <= '0;
            end
            OP_DIV: begin
                r_x <= w_t + X_W'(r_x[7:0]);
                r_q <= r_q + Q_W'(w_t);
            end
            OP_FIX:   r_diff <= $signed(DIFF_W'(w_qf)) - DIFF_W'($signed(w_mean));
            OP_MLO:   r_p <= P_W'(w_pp);
            OP_MHI:   r_p <= r_p + (P_W'(w_pp) <<< HALF_W);
            OP_RND: begin
                case (i_cmd.ch)
                    CH_RED:   r_red   <= w_sat;
                    CH_GREEN: r_green <= w_sat;
                    CH_BLUE:  r_blue  <= w_sat;
                    default:  r_blue  <= r_blue;
                endcase
            end
            default: r_acc <= r_acc;
        endcase
    end

    // Output register: hold the pixel until taken
    assign o_sts.out_free = !r_o_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            r_o_index <= i_cmd.index;
            r_o_red   <= r_red;
            r_o_green <= r_green;
            r_o_blue  <= r_blue;
            r_o_last  <= i_cmd.last;
            r_o_fend  <= i_cmd.fend;
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.pixel_index  = r_o_index;
    assign o_res.red_out      = $signed(r_o_red);
    assign o_res.green_out    = $signed(r_o_green);
    assign o_res.blue_out     = $signed(r_o_blue);
    assign o_res.last_of_item = r_o_last;
    assign o_res.frame_end    = r_o_fend;

    `YTNRP_ASSERT_IMPL(a_fix_after_div, i_clk, i_rst_n, i_cmd.op == OP_FIX, o_sts.div_done)
    `YTNRP_ASSERT_NEXT(a_clamp_clears_quot, i_clk, i_rst_n, i_cmd.op == OP_CLAMP, r_q == '0)
    `YTNRP_ASSERT_NEXT(a_emit_fills, i_clk, i_rst_n, i_cmd.op == OP_EMIT, r_o_valid)

endmodule

// ===== hw/rtl/yuyv_to_normalized_rgb_planar_core.sv =====
// ----------------------------------------------------------------------------
// YUYV to normalised planar RGB core
// A new item is accepted only while the controller is idle, once the last
// pixel of the previous item has gone to the output register. The pace is set
// by the shared divide-by-255 loop and the two-pass 26x13 normalise multiplier,
// plus stalls.
// Reset (synchronous, active low) restores register defaults and the counter.
// ----------------------------------------------------------------------------
//
// One macropixel (Y0 U Y1 V) is taken into the datapath input register while
// the controller is idle. For each pixel, each channel is then worked through
// the shared unit in turn:
//   load   Y*2^24 plus the first chroma term (green takes a second term)
//   clamp  limit to 0..255 in Q.24, add half a step and drop 24-F bits
//   div    divide by 255, one base-256 digit per cycle until under 256
//   fix    final correction, subtract the channel mean
//   mlo/mhi multiply by the reciprocal std in two 12-bit halves
//   rnd    round half up to Q.F, saturate to signed 24 bits
// The finished pixel moves to the output register; the datapath goes on with
// the next pixel or returns to idle while that pixel waits to be taken.
//
// The pixel counter lives in the controller. It restarts at zero at the end
// of the frame, and also before an item when a new frame size has left it
// outside the frame. An odd-sized frame ends on a single-pixel item.

module yuyv_to_normalized_rgb_planar_core import ytnrp_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ytnrp_pix_if.sink   i_pix,
    ytnrp_res_if.source o_res,
    ytnrp_cfg_if.sink   i_cfg
);

    logic [CFG_DIM_W-1:0] r_frame_width;
    logic [CFG_DIM_W-1:0] r_frame_height;
    t_ch24                r_mean;
    t_ch24                r_inv_std;

    t_cmd w_cmd;
    t_sts w_sts;

    // Configuration registers: always ready, written whenever a write is valid
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_DIM_W'(1);
            r_frame_height <= CFG_DIM_W'(1);
            r_mean         <= '0;
            r_inv_std      <= {3{DATA_W'(65536)}};
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_FRAME_WIDTH:   r_frame_width  <= i_cfg.data[CFG_DIM_W-1:0];
                REG_FRAME_HEIGHT:  r_frame_height <= i_cfg.data[CFG_DIM_W-1:0];
                REG_MEAN_RED:      r_mean[0]      <= i_cfg.data;
                REG_MEAN_GREEN:    r_mean[1]      <= i_cfg.data;
                REG_MEAN_BLUE:     r_mean[2]      <= i_cfg.data;
                REG_INV_STD_RED:   r_inv_std[0]   <= i_cfg.data;
                REG_INV_STD_GREEN: r_inv_std[1]   <= i_cfg.data;
                REG_INV_STD_BLUE:  r_inv_std[2]   <= i_cfg.data;
                default:           r_mean         <= r_mean;
            endcase
        end
    end

    // Controller: frame counter and step sequence
    ytnrp_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_pix.valid),
        .o_in_ready     (i_pix.ready),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_cmd          (w_cmd),
        .i_sts          (w_sts)
    );

    // Datapath: colour conversion, scaling, normalisation, output register
    ytnrp_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_luma_first  (i_pix.luma_first),
        .i_chroma_blue (i_pix.chroma_blue),
        .i_luma_second (i_pix.luma_second),
        .i_chroma_red  (i_pix.chroma_red),
        .i_mean        (r_mean),
        .i_inv_std     (r_inv_std),
        .o_res         (o_res)
    );

endmodule

// ===== bench/yuyv_to_normalized_rgb_planar_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// YUYV to normalised planar RGB core: self-checking testbench
// Feeds macropixels through the input channel and predicts every pixel that
// the core should emit. It compares each taken pixel field by field against
// the oldest prediction. Frame size, channel means and reciprocal deviations
// are rewritten between phases, and both channel ends pause at random.
// ----------------------------------------------------------------------------
module yuyv_to_normalized_rgb_planar_core_test import ytnrp_pkg::*;;

    localparam int FRAC       = 16;
    localparam int MAX_W      = 4096;
    localparam int MAX_H      = 4096;
    localparam int LONG_HOLD  = 300;   // receiver hold-off in the pressure phase
    localparam int IDLE_LIMIT = 3000;  // cycles with no handshake before giving up
    localparam int TAIL_WAIT  = 50;    // past the worst first-pixel latency

    // Full-range BT.601 coefficients in Q.24, positive magnitudes
    localparam longint K_RV = 64'sd23521657;
    localparam longint K_GU = 64'sd5773644;
    localparam longint K_GV = 64'sd11981214;
    localparam longint K_BU = 64'sd29729227;

    localparam longint CLAMP_TOP = 64'sd255 <<< 24;
    localparam longint STEP      = 64'sd255 <<< (24 - FRAC);
    localparam longint HALF_LSB  = 64'sd1 <<< (FRAC - 1);
    localparam longint SAT_HI    = 64'sd8388607;
    localparam longint SAT_LO    = -64'sd8388608;

    typedef struct packed {
        logic [7:0] luma_a;
        logic [7:0] cb;
        logic [7:0] luma_b;
        logic [7:0] cr;
    } macropixel_t;

    typedef struct packed {
        logic [DATA_W-1:0]        index;
        logic signed [DATA_W-1:0] red;
        logic signed [DATA_W-1:0] green;
        logic signed [DATA_W-1:0] blue;
        logic                     last;
        logic                     fend;
    } pixel_t;

    logic i_clk;
    logic i_rst_n;

    ytnrp_pix_if pix_ch ();
    ytnrp_res_if res_ch ();
    ytnrp_cfg_if cfg_ch ();

    yuyv_to_normalized_rgb_planar_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H),
        .FRAC_BITS  (FRAC)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Stimulus waiting to be offered, and pixels predicted but not yet seen
    macropixel_t macropixels[$];
    pixel_t      expected_pixels[$];

    // Shadow of the core's registers and its pixel counter
    logic [12:0] model_width;
    logic [12:0] model_height;
    longint      model_mean [3];
    longint      model_inv_std [3];
    longint      next_pixel;

    // Idling controls, set by the sequence between phases
    bit src_gaps_on;
    bit sink_stalls_on;
    int hold_requests;

    int mismatches;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Clamp a Q.24 channel, scale it to 0..1 in Q.F, then subtract the mean,
    // multiply by the reciprocal deviation, round half up and saturate.
    function automatic logic [DATA_W-1:0] normalise(longint acc, longint mean,
                                                    longint inv_std);
        longint scaled;
        longint prod;
        if (acc < 0) acc = 0;
        if (acc > CLAMP_TOP) acc = CLAMP_TOP;
        scaled = (acc + STEP / 2) / STEP;
        prod   = (scaled - mean) * inv_std;
        prod   = (prod + HALF_LSB) >>> FRAC;
        if (prod > SAT_HI) prod = SAT_HI;
        if (prod < SAT_LO) prod = SAT_LO;
        return prod[DATA_W-1:0];
    endfunction

    function automatic pixel_t convert_pixel(longint idx, logic [7:0] luma, longint u,
                                             longint v, logic last, logic fend);
        pixel_t px;
        longint yq;
        yq       = longint'(luma) <<< 24;
        px.index = idx[DATA_W-1:0];
        px.red   = normalise(yq + K_RV * v, model_mean[0], model_inv_std[0]);
        px.green = normalise(yq - K_GU * u - K_GV * v, model_mean[1], model_inv_std[1]);
        px.blue  = normalise(yq + K_BU * u, model_mean[2], model_inv_std[2]);
        px.last  = last;
        px.fend  = fend;
        return px;
    endfunction

    // Work out the one or two pixels of an accepted macropixel and advance
    // the shadow counter the way the core walks the frame.
    task automatic predict_macropixel(input macropixel_t mp);
        longint w;
        longint h;
        longint total;
        longint idx;
        longint u;
        longint v;
        logic   two;
        w = longint'(model_width);
        h = longint'(model_height);
        if (w < 1) w = 1;
        if (w > MAX_W) w = MAX_W;
        if (h < 1) h = 1;
        if (h > MAX_H) h = MAX_H;
        total = w * h;
        // a new, smaller frame may have left the counter outside it
        if (next_pixel >= total) next_pixel = 0;
        idx = next_pixel;
        two = (idx + 1) < total;
        u   = longint'(mp.cb) - 128;
        v   = longint'(mp.cr) - 128;
        expected_pixels.push_back(convert_pixel(idx, mp.luma_a, u, v, !two,
                                                idx == total - 1));
        // an odd frame ends on a single pixel; drop the second luma then
        if (two) begin
            expected_pixels.push_back(convert_pixel(idx + 1, mp.luma_b, u, v, 1'b1,
                                                    idx + 1 == total - 1));
        end
        next_pixel = idx + 2;
        if (next_pixel >= total) next_pixel = 0;
    endtask

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------

    // Mostly short pauses, now and then a long one
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic macropixel_t random_macropixel();
        macropixel_t mp;
        mp.luma_a = random_byte();
        mp.cb     = random_byte();
        mp.luma_b = random_byte();
        mp.cr     = random_byte();
        return mp;
    endfunction

    // Small frames wrap often; zero and oversized values test the limits
    function automatic logic [DATA_W-1:0] random_dim();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return DATA_W'($urandom_range(4097, 8191));
            2: return DATA_W'(4096);
            3: return DATA_W'($urandom_range(10, 64));
            default: return DATA_W'($urandom_range(1, 9));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_mean();
        case ($urandom_range(0, 7))
            0: return 24'h80_0000;
            1: return 24'h7F_FFFF;
            2, 3: return DATA_W'($urandom);
            default: return DATA_W'($urandom_range(20000, 40000));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_inv_std();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 24'hFF_FFFF;
            2, 3: return DATA_W'($urandom);
            default: return DATA_W'($urandom_range(150000, 300000));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------------

    // One register write; return at a falling edge so that the caller can
    // queue items without racing the driver.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic add_macropixel(input logic [7:0] ya, input logic [7:0] u,
                                  input logic [7:0] yb, input logic [7:0] v);
        macropixels.push_back(macropixel_t'{ya, u, yb, v});
    endtask

    // Hold until every item has gone in and every predicted pixel came out
    task automatic drain();
        do @(negedge i_clk);
        while (macropixels.size() != 0 || pix_ch.valid || expected_pixels.size() != 0);
    endtask

    task automatic report_mismatch(input string what, input pixel_t want,
                                   input pixel_t got);
        if (mismatches < 10) begin
            $display("%0t: %s", $realtime, what);
            $display("  expected: idx %0d r %0d g %0d b %0d last %0b fend %0b",
                     want.index, $signed(want.red), $signed(want.green),
                     $signed(want.blue), want.last, want.fend);
            $display("  actual:   idx %0d r %0d g %0d b %0d last %0b fend %0b",
                     got.index, $signed(got.red), $signed(got.green),
                     $signed(got.blue), got.last, got.fend);
        end
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Configuration shadow: track every accepted register write
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_width  <= 13'd1;
            model_height <= 13'd1;
            for (int c = 0; c < 3; c++) begin
                model_mean[c]    <= 0;
                model_inv_std[c] <= 65536;
            end
        end else if (cfg_ch.valid && cfg_ch.ready) begin
            case (cfg_ch.index)
                REG_FRAME_WIDTH:   model_width      <= cfg_ch.data[12:0];
                REG_FRAME_HEIGHT:  model_height     <= cfg_ch.data[12:0];
                REG_MEAN_RED:      model_mean[0]    <= longint'($signed(cfg_ch.data));
                REG_MEAN_GREEN:    model_mean[1]    <= longint'($signed(cfg_ch.data));
                REG_MEAN_BLUE:     model_mean[2]    <= longint'($signed(cfg_ch.data));
                REG_INV_STD_RED:   model_inv_std[0] <= longint'(cfg_ch.data);
                REG_INV_STD_GREEN: model_inv_std[1] <= longint'(cfg_ch.data);
                REG_INV_STD_BLUE:  model_inv_std[2] <= longint'(cfg_ch.data);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Driver: offer queued macropixels, predict each one as it is taken
    // ------------------------------------------------------------------------
    int gap_left;

    always @(posedge i_clk) begin
        macropixel_t mp;
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
            gap_left     <= 0;
            next_pixel    = 0;
        end else begin
            if (pix_ch.valid && pix_ch.ready) begin
                predict_macropixel('{pix_ch.luma_first, pix_ch.chroma_blue,
                                     pix_ch.luma_second, pix_ch.chroma_red});
            end
            // advance only when the bus is free or its item was just taken
            if (!pix_ch.valid || pix_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left     <= gap_left - 1;
                    pix_ch.valid <= 1'b0;
                end else if (macropixels.size() != 0) begin
                    mp = macropixels.pop_front();
                    pix_ch.valid       <= 1'b1;
                    pix_ch.luma_first  <= mp.luma_a;
                    pix_ch.chroma_blue <= mp.cb;
                    pix_ch.luma_second <= mp.luma_b;
                    pix_ch.chroma_red  <= mp.cr;
                    if (src_gaps_on && $urandom_range(0, 99) < 35) begin
                        gap_left <= idle_length();
                    end
                end else begin
                    pix_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each taken pixel and decide when to accept the next
    // ------------------------------------------------------------------------
    int hold_served;
    int hold_left;
    int stall_left;

    always @(posedge i_clk) begin
        pixel_t got;
        pixel_t want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            hold_served  <= 0;
            hold_left    <= 0;
            stall_left   <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got.index = res_ch.pixel_index;
                got.red   = res_ch.red_out;
                got.green = res_ch.green_out;
                got.blue  = res_ch.blue_out;
                got.last  = res_ch.last_of_item;
                got.fend  = res_ch.frame_end;
                if (expected_pixels.size() == 0) begin
                    report_mismatch("pixel with nothing predicted", '0, got);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got !== want) report_mismatch("pixel mismatch", want, got);
                end
            end
            // a fresh hold request overrides any short stall in progress
            if (hold_requests != hold_served) begin
                hold_served  <= hold_requests;
                hold_left    <= LONG_HOLD;
                res_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                res_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left   <= stall_left - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if (sink_stalls_on && $urandom_range(0, 99) < 30) begin
                    stall_left <= idle_length();
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: give up after a long run of cycles with no handshake at all
    // ------------------------------------------------------------------------
    int quiet_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d pixels outstanding",
                     $realtime, IDLE_LIMIT, expected_pixels.size());
            $display("** yuyv_to_normalized_rgb_planar_core: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: directed phases, then random phases, then the verdict
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n             = 1'b0;
        pix_ch.valid        = 1'b0;
        pix_ch.luma_first   = '0;
        pix_ch.chroma_blue  = '0;
        pix_ch.luma_second  = '0;
        pix_ch.chroma_red   = '0;
        res_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        src_gaps_on         = 1'b1;
        sink_stalls_on      = 1'b1;
        hold_requests       = 0;
        mismatches          = 0;
        quiet_cycles        = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Register defaults: a one-pixel frame, so every item emits its
        // first pixel alone, marked both last of item and end of frame.
        add_macropixel(8'h00, 8'h00, 8'h00, 8'h00);
        add_macropixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        add_macropixel(8'h00, 8'h80, 8'hFF, 8'h80);
        add_macropixel(8'hFF, 8'h00, 8'h00, 8'hFF);
        add_macropixel(8'h10, 8'hFF, 8'hEB, 8'h00);
        drain();

        // Three-pixel frame: a pair, then a lone pixel closing the frame,
        // and the counter returns to zero for the next frame.
        write_reg(REG_FRAME_WIDTH, 24'd3);
        write_reg(REG_FRAME_HEIGHT, 24'd1);
        add_macropixel(8'h0A, 8'h5A, 8'hF0, 8'h36);
        add_macropixel(8'hC8, 8'hA0, 8'h1E, 8'hC8);
        add_macropixel(8'h51, 8'h5A, 8'h91, 8'hF0);
        add_macropixel(8'h29, 8'hF0, 8'hD2, 8'h22);
        drain();

        // Zero width counts as one: a five-pixel column with odd pairing.
        // Extreme means and a maximal reciprocal drive saturation both ways;
        // a zero reciprocal flattens blue.
        write_reg(REG_FRAME_WIDTH, 24'd0);
        write_reg(REG_FRAME_HEIGHT, 24'd5);
        write_reg(REG_MEAN_RED, 24'h7F_FFFF);
        write_reg(REG_MEAN_GREEN, 24'h80_0000);
        write_reg(REG_MEAN_BLUE, 24'd0);
        write_reg(REG_INV_STD_RED, 24'hFF_FFFF);
        write_reg(REG_INV_STD_GREEN, 24'hFF_FFFF);
        write_reg(REG_INV_STD_BLUE, 24'd0);
        add_macropixel(8'hFF, 8'h00, 8'h00, 8'hFF);
        add_macropixel(8'h00, 8'hFF, 8'hFF, 8'h00);
        add_macropixel(8'h80, 8'h80, 8'h80, 8'h80);
        drain();

        // Oversized width saturates; leave the counter deep in the frame,
        // then shrink the frame so that it must restart from zero.
        write_reg(REG_FRAME_WIDTH, 24'd8191);
        write_reg(REG_FRAME_HEIGHT, 24'd3);
        write_reg(REG_MEAN_RED, 24'd31785);
        write_reg(REG_MEAN_GREEN, 24'd29798);
        write_reg(REG_MEAN_BLUE, 24'd26542);
        write_reg(REG_INV_STD_RED, 24'd286193);
        write_reg(REG_INV_STD_GREEN, 24'd292578);
        write_reg(REG_INV_STD_BLUE, 24'd291271);
        add_macropixel(8'h40, 8'h30, 8'hC0, 8'hD0);
        add_macropixel(8'h7F, 8'h81, 8'h80, 8'h7E);
        add_macropixel(8'hAA, 8'h55, 8'h55, 8'hAA);
        drain();
        write_reg(REG_FRAME_WIDTH, 24'd2);
        write_reg(REG_FRAME_HEIGHT, 24'd1);
        add_macropixel(8'h01, 8'hFE, 8'hFE, 8'h01);
        add_macropixel(8'h33, 8'hCC, 8'h99, 8'h66);
        add_macropixel(8'hE0, 8'h20, 8'h08, 8'hF8);
        drain();

        // Random phases: new registers each time, then a block of items.
        // Phase one holds the receiver off while the sender keeps offering,
        // so the core fills and stalls its input; phase two runs flat out.
        for (int phase = 0; phase < 8; phase++) begin
            write_reg(REG_FRAME_WIDTH, random_dim());
            write_reg(REG_FRAME_HEIGHT, random_dim());
            write_reg(REG_MEAN_RED, random_mean());
            write_reg(REG_MEAN_GREEN, random_mean());
            write_reg(REG_MEAN_BLUE, random_mean());
            write_reg(REG_INV_STD_RED, random_inv_std());
            write_reg(REG_INV_STD_GREEN, random_inv_std());
            write_reg(REG_INV_STD_BLUE, random_inv_std());
            src_gaps_on    = (phase != 1) && (phase != 2);
            sink_stalls_on = (phase != 1) && (phase != 2);
            if (phase == 1) hold_requests++;
            for (int k = 0; k < 104; k++) macropixels.push_back(random_macropixel());
            drain();
        end

        // Let any stray pixel surface before the verdict
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("** yuyv_to_normalized_rgb_planar_core: PASSED **");
        end else begin
            $display("** yuyv_to_normalized_rgb_planar_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ytnrp_pkg.sv
hw/rtl/ytnrp_if.sv
hw/rtl/ytnrp_ctrl.sv
hw/rtl/ytnrp_dp.sv
hw/rtl/yuyv_to_normalized_rgb_planar_core.sv
bench/yuyv_to_normalized_rgb_planar_core_test.sv
